### rtl/d2f_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d2f_pkg
// shared types and constants for the decimal to binary32 converter
// ----------------------------------------------------------------------------
package d2f_pkg;

  localparam int unsigned SigW = 24;
  localparam int unsigned ExpW = 9;
  localparam int unsigned FloatW = 32;
  localparam int unsigned ScaleW = 5;
  localparam int unsigned ExpBias = 127;

  // request into the divide-by-ten unit
  typedef struct packed {
    logic            start;
    logic [SigW-1:0] sig;
  } d2f_div_req_t;

  // response from the divide-by-ten unit
  typedef struct packed {
    logic            done;
    logic [SigW-1:0] sig;
    logic [2:0]      exp_drop;
  } d2f_div_rsp_t;

endpackage

### rtl/d2f_div10.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d2f_div10
// registered divide of a normalized 24-bit significand by ten, rounded to
// nearest even back into 24 bits, with the matching exponent drop
// ----------------------------------------------------------------------------
module d2f_div10 (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  d2f_pkg::d2f_div_req_t req_i,
  output d2f_pkg::d2f_div_rsp_t rsp_o
);
  import d2f_pkg::*;

  // quotient of sig << 28 by ten is {sig / 10, (sig % 10) << 28 / 10}
  localparam int unsigned ProdW  = 2 * SigW;
  localparam int unsigned QuoHiW = 21;
  localparam int unsigned QuoLoW = 28;
  localparam int unsigned QuoW   = QuoHiW + QuoLoW;
  // ceil(2^27 / 10) gives an exact floor(x / 10) for any 24-bit x
  localparam logic [SigW-1:0] RecipTen = 24'hCCCCCD;

  logic              mul_vld_q;
  logic [SigW-1:0]   sig_in_q;
  logic [ProdW-1:0]  prod_q;
  logic              done_q;
  logic [SigW-1:0]   sig_out_q, sig_out_d;
  logic [2:0]        drop_q, drop_d;

  logic [QuoHiW-1:0] quo_hi;
  logic [3:0]        digit;
  logic [QuoLoW-1:0] quo_lo;
  logic              rem_nz;
  logic [QuoW-1:0]   quo;
  logic [SigW-1:0]   ns;
  logic              rbit, sticky;
  logic [SigW:0]     rnd;
  logic [2:0]        drop_base;

  assign quo_hi = prod_q[ProdW-1 -: QuoHiW];
  // sig - 10 * (sig / 10)
  assign digit  = 4'(sig_in_q - SigW'({quo_hi, 3'b000}) - SigW'({quo_hi, 1'b0}));
  // 2^28 mod 10 is 6, so only digits 0 and 5 divide evenly
  assign rem_nz = !(digit inside {4'd0, 4'd5});

  always_comb begin
    case (digit)
      4'd1:    quo_lo = 28'd26843545;
      4'd2:    quo_lo = 28'd53687091;
      4'd3:    quo_lo = 28'd80530636;
      4'd4:    quo_lo = 28'd107374182;
      4'd5:    quo_lo = 28'd134217728;
      4'd6:    quo_lo = 28'd161061273;
      4'd7:    quo_lo = 28'd187904819;
      4'd8:    quo_lo = 28'd214748364;
      4'd9:    quo_lo = 28'd241591910;
      default: quo_lo = '0;
    endcase
  end

  assign quo = {quo_hi, quo_lo};

  // leading one of the quotient is at bit 48 or 47: exponent drops 3 or 4,
  // one less when rounding carries out
  always_comb begin
    if (quo[QuoW-1]) begin
      ns        = quo[QuoW-1 -: SigW];
      rbit      = quo[QuoW-1-SigW];
      sticky    = rem_nz || (quo[QuoW-2-SigW:0] != '0);
      drop_base = 3'd3;
    end else begin
      ns        = quo[QuoW-2 -: SigW];
      rbit      = quo[QuoW-2-SigW];
      sticky    = rem_nz || (quo[QuoW-3-SigW:0] != '0);
      drop_base = 3'd4;
    end
    rnd = {1'b0, ns} + (SigW+1)'(rbit && (sticky || ns[0]));
    if (rnd[SigW]) begin
      sig_out_d = rnd[SigW:1];
      drop_d    = drop_base - 3'd1;
    end else begin
      sig_out_d = rnd[SigW-1:0];
      drop_d    = drop_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      mul_vld_q <= req_i.start;
      done_q    <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sig_in_q <= req_i.sig;
      prod_q   <= ProdW'(req_i.sig) * ProdW'(RecipTen);
    end
    if (mul_vld_q) begin
      sig_out_q <= sig_out_d;
      drop_q    <= drop_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.sig      = sig_out_q;
  assign rsp_o.exp_drop = drop_q;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("div done held");
  a_norm_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rsp_o.sig[SigW-1]) else $error("quotient not normalized");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_vld_q || done_q) |-> !req_i.start) else $error("divider restarted while busy");
  a_drop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (drop_q >= 3'd2 && drop_q <= 3'd4)) else $error("exponent drop out of range");
`endif

endmodule

### rtl/decimal96_to_float_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal96_to_float_converter_core
// 96-bit decimal to ieee binary32, normalize then repeated rounded /10
// ----------------------------------------------------------------------------
// channel | ports                                              | handshake
// input   | mantissa_low_i mantissa_high_i decimal_scale_i negative_i | start_i, busy_o
// result  | float_bits_o                                       | done_o strobe
//
// normalize shifts one bit a cycle until the leading one is at the top,
// then one rounding step and one pass per unit of scale through the shared
// divide-by-ten unit: busy_o is high from the transfer until the result is
// out (a zero mantissa skips straight to the output)
// done_o pulses in the cycle busy_o drops; reset clears all core registers
// the result is flagged by done_o for one cycle and cannot be held off
module decimal96_to_float_converter_core #(
  parameter int unsigned MANTISSA_BITS = 96,
  parameter int unsigned MAX_SCALE     = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [63:0]                   mantissa_low_i,
  input  logic [31:0]                   mantissa_high_i,
  input  logic [d2f_pkg::ScaleW-1:0]    decimal_scale_i,
  input  logic                          negative_i,
  output logic                          done_o,
  output logic [d2f_pkg::FloatW-1:0]    float_bits_o
);
  import d2f_pkg::*;

  localparam int unsigned MW = MANTISSA_BITS;
  localparam int unsigned PW = $clog2(MW);

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_ROUND, S_DIV, S_WAIT, S_OUT
  } state_e;

  state_e          state_q;
  logic [MW-1:0]   m_q;
  logic [PW-1:0]   p_q;
  logic [ScaleW-1:0] scale_q;
  logic            neg_q;
  logic [SigW-1:0] sig_q;
  logic [ExpW-1:0] exp_q;
  logic            done_q;
  logic [FloatW-1:0] res_q;

  d2f_div_req_t div_req;
  d2f_div_rsp_t div_rsp;

  d2f_div10 u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic [127:0] full_in;
  logic [MW-1:0] m_in;
  logic [ScaleW-1:0] scale_in;
  assign full_in  = {32'd0, mantissa_high_i, mantissa_low_i};
  assign m_in     = MW'(full_in);
  assign scale_in = (32'(decimal_scale_i) > 32'(MAX_SCALE)) ?
                    ScaleW'(MAX_SCALE) : decimal_scale_i;

  // rounding of the normalized mantissa to 24 bits
  logic [SigW:0] rsig;
  logic          rb, st;
  always_comb begin
    rb   = m_q[MW-SigW-1];
    st   = (m_q & ((MW'(1) << (MW-SigW-1)) - MW'(1))) != '0;
    rsig = {1'b0, m_q[MW-1 -: SigW]} + (SigW+1)'(rb && (st || m_q[MW-SigW]));
  end

  assign div_req.start = (state_q == S_DIV);
  assign div_req.sig   = sig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      m_q     <= '0;
      p_q     <= '0;
      scale_q <= '0;
      neg_q   <= 1'b0;
      sig_q   <= '0;
      exp_q   <= '0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            m_q     <= m_in;
            p_q     <= PW'(MW - 1);
            scale_q <= scale_in;
            neg_q   <= negative_i;
            if (m_in == '0) begin
              res_q   <= {negative_i, 31'd0};
              state_q <= S_OUT;
            end else begin
              state_q <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (m_q[MW-1]) begin
            state_q <= S_ROUND;
          end else begin
            m_q <= {m_q[MW-2:0], 1'b0};
            p_q <= p_q - 1'b1;
          end
        end
        S_ROUND: begin
          if (rsig[SigW]) begin
            sig_q <= rsig[SigW:1];
            exp_q <= ExpW'(p_q) + 1'b1;
          end else begin
            sig_q <= rsig[SigW-1:0];
            exp_q <= ExpW'(p_q);
          end
          state_q <= (scale_q == '0) ? S_OUT : S_DIV;
        end
        S_DIV: state_q <= S_WAIT;
        S_WAIT: begin
          if (div_rsp.done) begin
            sig_q   <= div_rsp.sig;
            exp_q   <= exp_q - ExpW'(div_rsp.exp_drop);
            scale_q <= scale_q - 1'b1;
            state_q <= (scale_q == ScaleW'(1)) ? S_OUT : S_DIV;
          end
        end
        S_OUT: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
          if (m_q != '0)
            res_q <= {neg_q, 8'(exp_q + ExpW'(ExpBias)), sig_q[SigW-2:0]};
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign float_bits_o = res_q;

`ifndef SYNTHESIS
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o || $past(state_q == S_OUT)) else $error("stray done");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
`endif

endmodule
